FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define BMI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bmi assertion failed");

// clocked assertion that also holds during reset
`define BMI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bmi assertion failed");

`endif

FILE: rtl/core/bmi_pkg.sv
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared types and operation codes of the bit manipulation execute unit.
// ----------------------------------------------------------------------------
package bmi_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned CNT_W  = 7;

    // operation codes
    localparam logic [2:0] OP_ADDR = 3'd0;
    localparam logic [2:0] OP_DEP  = 3'd1;
    localparam logic [2:0] OP_EXT  = 3'd2;
    localparam logic [2:0] OP_LZC  = 3'd3;
    localparam logic [2:0] OP_TZC  = 3'd4;

    // control that travels beside the data through the pipe
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic [3:0] dest;
    } t_ctl;

endpackage

FILE: rtl/core/bmi_agu.sv
// ----------------------------------------------------------------------------
// bmi_agu
// Scaled index address: 32-bit index sum, extend and scale, base add.
// Two register stages; the base add is left to the output stage.
// ----------------------------------------------------------------------------
module bmi_agu (
    input  logic                        i_clk,
    input  logic [31:0]                 i_index,
    input  logic [bmi_pkg::DATA_W-1:0]  i_base,
    input  logic signed [19:0]          i_displacement,
    input  logic [2:0]                  i_scale_shift,
    input  logic                        i_logical_index,
    input  logic                        i_index_present,
    input  logic                        i_base_present,
    output logic [bmi_pkg::DATA_W-1:0]  o_scaled,
    output logic [bmi_pkg::DATA_W-1:0]  o_base
);

    logic [31:0]                n_sum;
    logic [bmi_pkg::DATA_W-1:0] n_ext;
    logic [bmi_pkg::DATA_W-1:0] r_ext;
    logic [2:0]                 r_sh;
    logic [bmi_pkg::DATA_W-1:0] r_base1;
    logic [bmi_pkg::DATA_W-1:0] r_scaled;
    logic [bmi_pkg::DATA_W-1:0] r_base2;

    // index sum wraps at 32 bits, then zero or sign extension
    always_comb begin
        n_sum = 32'(i_displacement) + (i_index_present ? i_index : 32'd0);
        n_ext = i_logical_index ? {32'd0, n_sum} : {{32{n_sum[31]}}, n_sum};
    end

    // stage 1 and stage 2 registers
    always_ff @(posedge i_clk) begin
        r_ext    <= n_ext;
        r_sh     <= i_scale_shift;
        r_base1  <= i_base_present ? i_base : '0;
        r_scaled <= r_ext << r_sh;
        r_base2  <= r_base1;
    end

    assign o_scaled = r_scaled;
    assign o_base   = r_base2;

endmodule

FILE: rtl/core/bmi_perm.sv
// ----------------------------------------------------------------------------
// bmi_perm
// MSB-first bit deposit and extract. Stage 1 ranks every mask bit by the
// number of set mask bits above it; stage 2 routes bits by that rank.
// ----------------------------------------------------------------------------
module bmi_perm (
    input  logic                        i_clk,
    input  logic [bmi_pkg::DATA_W-1:0]  i_val,
    input  logic [bmi_pkg::DATA_W-1:0]  i_mask,
    output logic [bmi_pkg::DATA_W-1:0]  o_dep,
    output logic [bmi_pkg::DATA_W-1:0]  o_ext
);

    logic [bmi_pkg::POS_W-1:0]  n_rank [bmi_pkg::DATA_W];
    logic [bmi_pkg::POS_W-1:0]  r_rank [bmi_pkg::DATA_W];
    logic [bmi_pkg::DATA_W-1:0] r_val;
    logic [bmi_pkg::DATA_W-1:0] r_mask;
    logic [bmi_pkg::DATA_W-1:0] n_dep;
    logic [bmi_pkg::DATA_W-1:0] n_ext;
    logic [bmi_pkg::DATA_W-1:0] hit [bmi_pkg::DATA_W];
    logic [bmi_pkg::DATA_W-1:0] r_dep;
    logic [bmi_pkg::DATA_W-1:0] r_ext;

    // rank of each position: set mask bits strictly above it
    always_comb begin
        for (int i = 0; i < bmi_pkg::DATA_W; i++) begin
            n_rank[i] = bmi_pkg::POS_W'($countones(i_mask >> (i + 1)));
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
        r_val  <= i_val;
        r_mask <= i_mask;
    end

    // target position of rank k is 63-k, the bitwise inverse of k
    always_comb begin
        for (int i = 0; i < bmi_pkg::DATA_W; i++) begin
            n_dep[i] = r_mask[i] & r_val[~r_rank[i]];
        end
        for (int j = 0; j < bmi_pkg::DATA_W; j++) begin
            for (int i = 0; i < bmi_pkg::DATA_W; i++) begin
                hit[j][i] = r_mask[i] & r_val[i]
                          & (~r_rank[i] == bmi_pkg::POS_W'(j));
            end
            n_ext[j] = |hit[j];
        end
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        r_dep <= n_dep;
        r_ext <= n_ext;
    end

    assign o_dep = r_dep;
    assign o_ext = r_ext;

endmodule

FILE: rtl/core/bmi_cnt.sv
// ----------------------------------------------------------------------------
// bmi_cnt
// Leading and trailing zero counts, 64 for an all-zero value.
// One register stage.
// ----------------------------------------------------------------------------
module bmi_cnt (
    input  logic                        i_clk,
    input  logic [bmi_pkg::DATA_W-1:0]  i_val,
    output logic [bmi_pkg::CNT_W-1:0]   o_lz,
    output logic [bmi_pkg::CNT_W-1:0]   o_tz
);

    logic [bmi_pkg::CNT_W-1:0] n_lz;
    logic [bmi_pkg::CNT_W-1:0] n_tz;
    logic [bmi_pkg::CNT_W-1:0] r_lz;
    logic [bmi_pkg::CNT_W-1:0] r_tz;

    // priority encoders from each end
    always_comb begin
        n_lz = bmi_pkg::CNT_W'(bmi_pkg::DATA_W);
        n_tz = bmi_pkg::CNT_W'(bmi_pkg::DATA_W);
        for (int i = 0; i < bmi_pkg::DATA_W; i++) begin
            if (i_val[i]) begin
                n_lz = bmi_pkg::CNT_W'(bmi_pkg::DATA_W - 1 - i);
            end
        end
        for (int i = bmi_pkg::DATA_W - 1; i >= 0; i--) begin
            if (i_val[i]) begin
                n_tz = bmi_pkg::CNT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lz <= n_lz;
        r_tz <= n_tz;
    end

    assign o_lz = r_lz;
    assign o_tz = r_tz;

endmodule

FILE: rtl/core/bit_manip_and_index_exec_unit.sv
// o_strobe follows the accepting edge through the control pipe (r_s1, r_s2, r_strobe).
// Throughput: one transaction per cycle; busy is never raised.
// The slowest data path has three register stages (rank, route, select).
// Reset clears the stage valid bits and o_strobe; data registers are not reset.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// bit_manip_and_index_exec_unit
// Three-stage execute unit: index address, bit deposit/extract, zero counts.
// ----------------------------------------------------------------------------
module bit_manip_and_index_exec_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_op,
    input  logic [3:0]          i_dest_reg,
    input  logic [63:0]         i_operand_x,
    input  logic [63:0]         i_operand_y,
    input  logic signed [19:0]  i_displacement,
    input  logic [2:0]          i_scale_shift,
    input  logic                i_logical_index,
    input  logic                i_index_present,
    input  logic                i_base_present,
    output logic                o_strobe,
    output logic [3:0]          o_result_reg,
    output logic [63:0]         o_result_value
);

    bmi_pkg::t_ctl               r_s1;
    bmi_pkg::t_ctl               r_s2;
    logic [bmi_pkg::CNT_W-1:0]   lz_s1;
    logic [bmi_pkg::CNT_W-1:0]   tz_s1;
    logic [bmi_pkg::CNT_W-1:0]   r_lz_s2;
    logic [bmi_pkg::CNT_W-1:0]   r_tz_s2;
    logic [63:0]                 scaled;
    logic [63:0]                 base;
    logic [63:0]                 dep;
    logic [63:0]                 ext;
    logic [63:0]                 n_value;
    logic                        r_strobe;
    logic [3:0]                  r_result_reg;
    logic [63:0]                 r_result_value;

    assign busy = 1'b0;

    bmi_agu u_agu (
        .i_clk           (i_clk),
        .i_index         (i_operand_x[31:0]),
        .i_base          (i_operand_y),
        .i_displacement  (i_displacement),
        .i_scale_shift   (i_scale_shift),
        .i_logical_index (i_logical_index),
        .i_index_present (i_index_present),
        .i_base_present  (i_base_present),
        .o_scaled        (scaled),
        .o_base          (base)
    );

    bmi_perm u_perm (
        .i_clk  (i_clk),
        .i_val  (i_operand_x),
        .i_mask (i_operand_y),
        .o_dep  (dep),
        .o_ext  (ext)
    );

    bmi_cnt u_cnt (
        .i_clk (i_clk),
        .i_val (i_operand_x),
        .o_lz  (lz_s1),
        .o_tz  (tz_s1)
    );

    // control pipe with valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1.valid <= start;
            r_s2.valid <= r_s1.valid;
        end
        r_s1.op   <= i_op;
        r_s1.dest <= i_dest_reg;
        r_s2.op   <= r_s1.op;
        r_s2.dest <= r_s1.dest;
        r_lz_s2   <= lz_s1;
        r_tz_s2   <= tz_s1;
    end

    // final select, base add for the address op
    always_comb begin
        case (r_s2.op)
            bmi_pkg::OP_ADDR: n_value = scaled + base;
            bmi_pkg::OP_DEP:  n_value = dep;
            bmi_pkg::OP_EXT:  n_value = ext;
            bmi_pkg::OP_LZC:  n_value = 64'(r_lz_s2);
            bmi_pkg::OP_TZC:  n_value = 64'(r_tz_s2);
            default:          n_value = '0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s2.valid;
        end
        r_result_reg   <= r_s2.dest;
        r_result_value <= n_value;
    end

    assign o_strobe       = r_strobe;
    assign o_result_reg   = r_result_reg;
    assign o_result_value = r_result_value;

endmodule

FILE: rtl/core/bmi_chk.sv
// ----------------------------------------------------------------------------
// bmi_chk
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmi_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input logic [2:0]   i_op,
    input logic [3:0]   i_dest_reg,
    input logic         o_strobe,
    input logic [3:0]   o_result_reg,
    input logic [63:0]  o_result_value
);

    // unit never stalls the issuer
    `BMI_ASSERT_ALWAYS(a_never_busy, i_clk, !busy)

    // every transaction yields one result on o_strobe
    `BMI_ASSERT(a_result_follows, i_clk, i_rst_n, start |-> ##3 o_strobe)

    // no result without a transaction
    `BMI_ASSERT(a_no_spurious, i_clk, i_rst_n, !start |-> ##3 !o_strobe)

    // destination register travels with its transaction
    `BMI_ASSERT(a_dest_kept, i_clk, i_rst_n,
        o_strobe |-> o_result_reg == $past(i_dest_reg, 3))

    // zero counts stay within 0..64
    `BMI_ASSERT(a_count_range, i_clk, i_rst_n,
        (o_strobe && $past(start && (i_op == bmi_pkg::OP_LZC ||
            i_op == bmi_pkg::OP_TZC), 3)) |-> o_result_value <= 64'd64)

endmodule

bind bit_manip_and_index_exec_unit bmi_chk u_bmi_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .i_dest_reg     (i_dest_reg),
    .o_strobe       (o_strobe),
    .o_result_reg   (o_result_reg),
    .o_result_value (o_result_value)
);
